// ===== hdl/clg_pkg.sv =====
// Shared types and constants for the Coleman-Liau text grader.
// Used by clg_ctrl, clg_datapath and the top level coleman_liau_text_grader.
package clg_pkg;

    localparam int COUNT_BITS = 16;
    localparam int OUT_BITS   = 16;
    localparam int GRADE_BITS = 5;

    // Widths of the fixed-point terms: each constant factor sets the growth.
    localparam int PL_BITS  = COUNT_BITS + 10;  // 588 * letters
    localparam int PS_BITS  = COUNT_BITS + 12;  // 2960 * sentences
    localparam int PW_BITS  = COUNT_BITS + 11;  // 1580 * words
    localparam int NEG_BITS = COUNT_BITS + 13;  // sum of the two negative terms
    localparam int DEN_BITS = COUNT_BITS + 7;   // 100 * words
    localparam int ACC_BITS = COUNT_BITS + 12;  // dividend and shifted divisor

    localparam int COEF_L = 588;
    localparam int COEF_S = 2960;
    localparam int COEF_W = 1580;
    localparam int COEF_D = 100;

    localparam int GRADE_MAX = 16;
    localparam int DIV_STEPS = 5;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    localparam logic [7:0] CHAR_PERIOD   = 8'd46;
    localparam logic [7:0] CHAR_EXCLAIM  = 8'd33;
    localparam logic [7:0] CHAR_QUESTION = 8'd63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_DIFF,
        ST_PREP,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } clg_state_t;

    typedef struct packed {
        logic byte_en;   // count one text byte
        logic eot_en;    // close the text, capture counts, clear counters
        logic mul_en;    // form the three products and the denominator
        logic sum_en;    // add the negative terms
        logic diff_en;   // numerator and sign
        logic prep_en;   // dividend and clamp limit
        logic check_en;  // clamp test, divisor setup
        logic div_en;    // one restoring division step
        logic load_out;  // move the result into the output registers
    } clg_cmd_t;

endpackage

// ===== hdl/clg_ctrl.sv =====
// Sequencer for the Coleman-Liau text grader: handshakes and step commands.
// Depends on clg_pkg; drives clg_datapath through clg_cmd_t.
module clg_ctrl
    import clg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     end_of_text,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output clg_cmd_t cmd
);

    clg_state_t state_reg, state_next;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg, div_cnt_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.byte_en = in_valid && !end_of_text;
                cmd.eot_en  = in_valid && end_of_text;
                if (in_valid && end_of_text)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff_en = 1'b1;
                state_next  = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep_en = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check_en = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_en = 1'b1;
                if (div_cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                // Wait until the output register is free or being emptied.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/clg_datapath.sv =====
// Counters, fixed-point grade arithmetic and output registers of the grader.
// Depends on clg_pkg; steered by clg_ctrl through clg_cmd_t.
module clg_datapath
    import clg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  clg_cmd_t              cmd,
    input  logic [7:0]            char_code,
    output logic [GRADE_BITS-1:0] grade,
    output logic [OUT_BITS-1:0]   letter_total,
    output logic [OUT_BITS-1:0]   word_total,
    output logic [OUT_BITS-1:0]   sentence_total,
    output logic                  no_words
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    // Whitespace or punctuation in the C locale: these bytes end a word.
    function automatic logic is_break(input logic [7:0] c);
        return (c >= 8'd9 && c <= 8'd13) || (c >= 8'd32 && c <= 8'd47) ||
               (c >= 8'd58 && c <= 8'd64) || (c >= 8'd91 && c <= 8'd96) ||
               (c >= 8'd123 && c <= 8'd126);
    endfunction

    logic [COUNT_BITS-1:0] letter_reg, word_reg, sent_reg;
    logic                  inword_reg;

    logic [COUNT_BITS-1:0] snap_l_reg, snap_w_reg, snap_s_reg;
    logic [PL_BITS-1:0]    pl_reg;
    logic [PS_BITS-1:0]    ps_reg;
    logic [PW_BITS-1:0]    pw_reg;
    logic [DEN_BITS-1:0]   den_reg;
    logic [NEG_BITS-1:0]   neg_reg;
    logic [PL_BITS-1:0]    num_reg;
    logic                  minus_reg;
    logic [ACC_BITS-1:0]   acc_reg;
    logic [ACC_BITS-1:0]   lim_reg;
    logic [ACC_BITS-1:0]   dvs_reg;
    logic [DIV_STEPS-1:0]  quo_reg;
    logic                  clamp_reg;

    logic [GRADE_BITS-1:0] grade_reg;
    logic [OUT_BITS-1:0]   l_out_reg, w_out_reg, s_out_reg;
    logic                  nw_reg;

    logic [COUNT_BITS-1:0] word_final;
    logic                  char_sent;
    logic [GRADE_BITS-1:0] grade_calc;

    assign word_final = inword_reg ? sat_inc(word_reg) : word_reg;
    assign char_sent  = (char_code == CHAR_PERIOD) || (char_code == CHAR_EXCLAIM) ||
                        (char_code == CHAR_QUESTION);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letter_reg <= '0;
            word_reg   <= '0;
            sent_reg   <= '0;
            inword_reg <= 1'b0;
        end
        else if (cmd.eot_en)
        begin
            letter_reg <= '0;
            word_reg   <= '0;
            sent_reg   <= '0;
            inword_reg <= 1'b0;
        end
        else if (cmd.byte_en)
        begin
            if (is_letter(char_code))
            begin
                letter_reg <= sat_inc(letter_reg);
            end
            if (char_sent)
            begin
                sent_reg <= sat_inc(sent_reg);
            end
            if (is_break(char_code))
            begin
                if (inword_reg)
                begin
                    word_reg <= sat_inc(word_reg);
                end
                inword_reg <= 1'b0;
            end
            else
            begin
                inword_reg <= 1'b1;
            end
        end
    end

    // Grade pipeline: products, numerator, then a restoring division that
    // yields a five-bit quotient once the clamp to the top grade is ruled out.
    always_ff @(posedge clk)
    begin
        if (cmd.eot_en)
        begin
            snap_l_reg <= letter_reg;
            snap_w_reg <= word_final;
            snap_s_reg <= sent_reg;
        end
        if (cmd.mul_en)
        begin
            pl_reg  <= PL_BITS'(snap_l_reg * PL_BITS'(COEF_L));
            ps_reg  <= PS_BITS'(snap_s_reg * PS_BITS'(COEF_S));
            pw_reg  <= PW_BITS'(snap_w_reg * PW_BITS'(COEF_W));
            den_reg <= DEN_BITS'(snap_w_reg * DEN_BITS'(COEF_D));
        end
        if (cmd.sum_en)
        begin
            neg_reg <= NEG_BITS'(ps_reg) + NEG_BITS'(pw_reg);
        end
        if (cmd.diff_en)
        begin
            minus_reg <= neg_reg > NEG_BITS'(pl_reg);
            num_reg   <= pl_reg - PL_BITS'(neg_reg);
        end
        if (cmd.prep_en)
        begin
            // Dividend 2*num + den against divisor 2*den; 17 divisors = 34*den.
            acc_reg <= ACC_BITS'({num_reg, 1'b0}) + ACC_BITS'(den_reg);
            lim_reg <= ACC_BITS'({den_reg, 5'b0}) + ACC_BITS'({den_reg, 1'b0});
        end
        if (cmd.check_en)
        begin
            clamp_reg <= acc_reg >= lim_reg;
            dvs_reg   <= ACC_BITS'({den_reg, 5'b0});
            quo_reg   <= '0;
        end
        if (cmd.div_en)
        begin
            if (acc_reg >= dvs_reg)
            begin
                acc_reg <= acc_reg - dvs_reg;
                quo_reg <= {quo_reg[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[DIV_STEPS-2:0], 1'b0};
            end
            dvs_reg <= dvs_reg >> 1;
        end
        if (cmd.load_out)
        begin
            grade_reg <= grade_calc;
            l_out_reg <= snap_l_reg[OUT_BITS-1:0];
            w_out_reg <= snap_w_reg[OUT_BITS-1:0];
            s_out_reg <= snap_s_reg[OUT_BITS-1:0];
            nw_reg    <= (snap_w_reg == '0);
        end
    end

    always_comb
    begin
        if (snap_w_reg == '0 || minus_reg)
        begin
            grade_calc = '0;
        end
        else if (clamp_reg)
        begin
            grade_calc = GRADE_BITS'(GRADE_MAX);
        end
        else
        begin
            grade_calc = GRADE_BITS'(quo_reg);
        end
    end

    assign grade          = grade_reg;
    assign letter_total   = l_out_reg;
    assign word_total     = w_out_reg;
    assign sentence_total = s_out_reg;
    assign no_words       = nw_reg;

endmodule

// ===== hdl/coleman_liau_text_grader.sv =====
// Channel   Handshake            Beat contents
// in        in_valid / in_ready  char_code, end_of_text
// out       out_valid/ out_ready grade, letter_total, word_total, sentence_total, no_words
//
// Bytes may arrive on every cycle while in_ready is high.
// A terminator beat runs the arithmetic (five setup steps, five restoring
// division steps, one load) before its result reaches the output register;
// in_ready is low during that time.
// Bytes are accepted while a result waits; a terminator waits in the last
// step until the output register is free. Reset is asynchronous, active low.
// Top level of the Coleman-Liau text grader; depends on clg_pkg, clg_ctrl
// and clg_datapath.
module coleman_liau_text_grader
    import clg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            char_code,
    input  logic                  end_of_text,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [GRADE_BITS-1:0] grade,
    output logic [OUT_BITS-1:0]   letter_total,
    output logic [OUT_BITS-1:0]   word_total,
    output logic [OUT_BITS-1:0]   sentence_total,
    output logic                  no_words
);

    clg_cmd_t cmd;

    clg_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .end_of_text (end_of_text),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cmd         (cmd)
    );

    clg_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .char_code      (char_code),
        .grade          (grade),
        .letter_total   (letter_total),
        .word_total     (word_total),
        .sentence_total (sentence_total),
        .no_words       (no_words)
    );

    // A terminator beat starts the arithmetic, so no beat is taken next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && end_of_text) |=> !in_ready)
        else $error("input taken while grade arithmetic runs");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_words) |-> (grade == '0))
        else $error("grade nonzero for a text with no words");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (grade <= GRADE_BITS'(GRADE_MAX)))
        else $error("grade above clamp");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_words) |-> (word_total == '0))
        else $error("no_words flag disagrees with word count");

endmodule
